// ===== hw/rtl/joypad_serial_port_multitap_top_defines.svh =====
// Assertion macros shared by the joypad serial port RTL.
// Depends on nothing; the using module must have clk and rst_n in scope.
`ifndef JOYPAD_SERIAL_PORT_MULTITAP_TOP_DEFINES_SVH
`define JOYPAD_SERIAL_PORT_MULTITAP_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define JSPM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset
`define JSPM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/jspm_pkg.sv =====
// Shared types, constants and shift helpers for the joypad serial port.
// Used by jspm_in_reg, jspm_core and the top level; depends on nothing.
package jspm_pkg;

  localparam int NUM_PADS         = 5;
  localparam int AUTO_READ_SHIFTS = 16;
  localparam int PAD_W            = 16;
  localparam int READ_W           = 5;
  localparam int NUM_WORDS        = 4;
  localparam int TOP_BIT          = 15;

  localparam logic [PAD_W-1:0]  LATCH_MASK  = 16'hFFF0;
  localparam logic [READ_W-1:0] PORT1_FIXED = 5'h1C;
  localparam logic [1:0]        TAP_PRESENT = 2'h2;

  // Command codes
  localparam logic [1:0] CMD_STROBE = 2'd0;
  localparam logic [1:0] CMD_READ0  = 2'd1;
  localparam logic [1:0] CMD_READ1  = 2'd2;
  localparam logic [1:0] CMD_AUTO   = 2'd3;

  // Ones in the low AUTO_READ_SHIFTS bits
  localparam logic [PAD_W-1:0] AUTO_FILL =
    PAD_W'((17'(1) << AUTO_READ_SHIFTS) - 17'(1));

  // Packed stream widths
  localparam int IN_DATA_BITS  = 1 + NUM_PADS * PAD_W + NUM_PADS + 1;
  localparam int IN_DATA_W     = ((IN_DATA_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_BITS = READ_W + NUM_WORDS * PAD_W;
  localparam int OUT_DATA_W    = ((OUT_DATA_BITS + 7) / 8) * 8;

  typedef logic [NUM_PADS-1:0][PAD_W-1:0]  pad_array_t;
  typedef logic [NUM_WORDS-1:0][PAD_W-1:0] word_array_t;

  // One input word after unpacking
  typedef struct packed {
    logic [1:0]          command;
    logic                strobe_value;
    pad_array_t          pad_buttons;
    logic [NUM_PADS-1:0] connected_mask;
    logic                port_select;
  } item_t;

  // Single serial read: shift left, fill with the connected bit
  function automatic logic [PAD_W-1:0] shift_one(input logic [PAD_W-1:0] x,
                                                 input logic fill);
    return {x[PAD_W-2:0], fill};
  endfunction

  // All dummy reads of an auto-read in one step
  function automatic logic [PAD_W-1:0] shift_auto(input logic [PAD_W-1:0] x,
                                                  input logic fill);
    logic [PAD_W-1:0] shifted;
    shifted = x << AUTO_READ_SHIFTS;
    return shifted | (fill ? AUTO_FILL : '0);
  endfunction

endpackage

// ===== hw/rtl/jspm_in_reg.sv =====
// Input register stage: unpacks the stream word into an item and holds it.
// Depends on jspm_pkg.
module jspm_in_reg (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [jspm_pkg::IN_DATA_W-1:0]    in_tdata,
  input  logic [1:0]                        in_tuser,
  input  logic                              take,
  output logic                              item_valid,
  output jspm_pkg::item_t                   item
);

  logic            valid_r;
  logic            valid_nxt;
  jspm_pkg::item_t item_r;
  jspm_pkg::item_t item_nxt;

  // Accept when empty or when the held word moves on this cycle
  assign in_tready = !valid_r || take;

  // Unpack fields from the lowest bit up
  always_comb begin
    item_nxt.command        = in_tuser;
    item_nxt.strobe_value   = in_tdata[0];
    for (int i = 0; i < jspm_pkg::NUM_PADS; i++) begin
      item_nxt.pad_buttons[i] = in_tdata[1 + i*jspm_pkg::PAD_W +: jspm_pkg::PAD_W];
    end
    item_nxt.connected_mask =
      in_tdata[1 + jspm_pkg::NUM_PADS*jspm_pkg::PAD_W +: jspm_pkg::NUM_PADS];
    item_nxt.port_select    =
      in_tdata[1 + jspm_pkg::NUM_PADS*jspm_pkg::PAD_W + jspm_pkg::NUM_PADS];
  end

  assign valid_nxt = (in_tvalid && in_tready) || (valid_r && !take);

  // Hold the valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Load the payload on accept
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r <= item_nxt;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

// ===== hw/rtl/jspm_core.sv =====
// Shift-register state, command logic and result register.
// Depends on jspm_pkg and joypad_serial_port_multitap_top_defines.svh.
`include "joypad_serial_port_multitap_top_defines.svh"

module jspm_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              item_valid,
  input  jspm_pkg::item_t                   item,
  output logic                              take,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [jspm_pkg::OUT_DATA_W-1:0]   out_tdata
);

  jspm_pkg::pad_array_t             pad_shift_r;
  jspm_pkg::pad_array_t             pad_shift_nxt;
  jspm_pkg::pad_array_t             latched;
  logic                             strobe_r;
  logic                             strobe_nxt;
  jspm_pkg::word_array_t            words_r;
  jspm_pkg::word_array_t            words_nxt;
  logic                             out_valid_r;
  logic                             out_valid_nxt;
  logic [jspm_pkg::READ_W-1:0]      read_r;
  logic [jspm_pkg::READ_W-1:0]      read_nxt;
  jspm_pkg::word_array_t            joy_r;
  logic                             tap;
  logic [1:0]                       port1_bits;
  logic [jspm_pkg::NUM_PADS-1:0]    conn;

  // Advance when the result register is free or drains this cycle
  assign take = item_valid && (!out_valid_r || out_tready);

  assign conn = item.connected_mask;
  assign tap  = |conn[4:2];

  // Strobe latch values: upper button bits, zero when disconnected
  always_comb begin
    for (int i = 0; i < jspm_pkg::NUM_PADS; i++) begin
      latched[i] = conn[i] ? (item.pad_buttons[i] & jspm_pkg::LATCH_MASK) : '0;
    end
  end

  // Next state and read value for one word
  always_comb begin
    pad_shift_nxt = pad_shift_r;
    strobe_nxt    = strobe_r;
    words_nxt     = words_r;
    read_nxt      = '0;
    port1_bits    = '0;
    case (item.command)
      jspm_pkg::CMD_STROBE: begin
        if (item.strobe_value && !strobe_r) begin
          pad_shift_nxt = latched;
        end
        strobe_nxt = item.strobe_value;
      end
      jspm_pkg::CMD_READ0: begin
        read_nxt = {{(jspm_pkg::READ_W-1){1'b0}}, pad_shift_r[0][jspm_pkg::TOP_BIT]};
        if (!strobe_r) begin
          pad_shift_nxt[0] = jspm_pkg::shift_one(pad_shift_r[0], conn[0]);
        end
      end
      jspm_pkg::CMD_READ1: begin
        if (!tap) begin
          port1_bits = {1'b0, pad_shift_r[1][jspm_pkg::TOP_BIT]};
          if (!strobe_r) begin
            pad_shift_nxt[1] = jspm_pkg::shift_one(pad_shift_r[1], conn[1]);
          end
        end else if (strobe_r) begin
          port1_bits = jspm_pkg::TAP_PRESENT;
        end else if (item.port_select) begin
          port1_bits = {pad_shift_r[2][jspm_pkg::TOP_BIT], pad_shift_r[1][jspm_pkg::TOP_BIT]};
          pad_shift_nxt[1] = jspm_pkg::shift_one(pad_shift_r[1], conn[1]);
          pad_shift_nxt[2] = jspm_pkg::shift_one(pad_shift_r[2], conn[2]);
        end else begin
          port1_bits = {pad_shift_r[4][jspm_pkg::TOP_BIT], pad_shift_r[3][jspm_pkg::TOP_BIT]};
          pad_shift_nxt[3] = jspm_pkg::shift_one(pad_shift_r[3], conn[3]);
          pad_shift_nxt[4] = jspm_pkg::shift_one(pad_shift_r[4], conn[4]);
        end
        read_nxt = {{(jspm_pkg::READ_W-2){1'b0}}, port1_bits} | jspm_pkg::PORT1_FIXED;
      end
      jspm_pkg::CMD_AUTO: begin
        // Latch always happens; capture words, then apply the dummy reads
        words_nxt[0] = latched[0];
        words_nxt[1] = latched[1];
        words_nxt[2] = item.port_select ? latched[1] : latched[3];
        words_nxt[3] = item.port_select ? latched[2] : latched[4];
        pad_shift_nxt    = latched;
        pad_shift_nxt[0] = jspm_pkg::shift_auto(latched[0], conn[0]);
        if (!tap) begin
          pad_shift_nxt[1] = jspm_pkg::shift_auto(latched[1], conn[1]);
        end else if (item.port_select) begin
          pad_shift_nxt[1] = jspm_pkg::shift_auto(latched[1], conn[1]);
          pad_shift_nxt[2] = jspm_pkg::shift_auto(latched[2], conn[2]);
        end else begin
          pad_shift_nxt[3] = jspm_pkg::shift_auto(latched[3], conn[3]);
          pad_shift_nxt[4] = jspm_pkg::shift_auto(latched[4], conn[4]);
        end
        strobe_nxt = 1'b0;
      end
      default: begin
        pad_shift_nxt = pad_shift_r;
      end
    endcase
  end

  // Update state on advance
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pad_shift_r <= '0;
      strobe_r    <= 1'b0;
      words_r     <= '0;
    end else if (take) begin
      pad_shift_r <= pad_shift_nxt;
      strobe_r    <= strobe_nxt;
      words_r     <= words_nxt;
    end
  end

  assign out_valid_nxt = take || (out_valid_r && !out_tready);

  // Hold the result valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Load the result payload on advance
  always_ff @(posedge clk) begin
    if (take) begin
      read_r <= read_nxt;
      joy_r  <= words_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(jspm_pkg::OUT_DATA_W - jspm_pkg::OUT_DATA_BITS){1'b0}},
                       joy_r[3], joy_r[2], joy_r[1], joy_r[0], read_r};

  `JSPM_ASSERT_NEXT(a_auto_clears_strobe, take && item.command == jspm_pkg::CMD_AUTO,
    !strobe_r, "auto-read left strobe high")
  `JSPM_ASSERT_NEXT(a_port1_fixed_bits, take && item.command == jspm_pkg::CMD_READ1,
    read_r[4:2] == 3'b111, "port 1 read lost fixed bits")
  `JSPM_ASSERT_NEXT(a_strobe_read_zero, take && item.command == jspm_pkg::CMD_STROBE,
    read_r == '0, "strobe write gave nonzero read data")
  `JSPM_ASSERT_NEXT(a_port0_hold, take && item.command == jspm_pkg::CMD_READ0 && strobe_r,
    $stable(pad_shift_r[0]), "port 0 shifted while strobe high")

endmodule

// ===== hw/rtl/joypad_serial_port_multitap_top.sv =====
// Top level of the five-pad serial joypad port with multitap.
// Depends on jspm_pkg, jspm_in_reg and jspm_core.
//
// Usage:
//   Input stream: in_tuser carries the command (strobe write, read port 0,
//   read port 1, auto-read); in_tdata carries the strobe bit, the five pad
//   button words, the connected mask and the port select.
//   Output stream: one word per input word, carrying the serial read value
//   and the four auto-read joy words.
//   Path: an accepted word sits in the input register until the core takes
//   it, which loads the result register and raises out_tvalid.
//   Throughput: one word per cycle if out_tready is high; every command,
//   auto-read included, finishes in a single pass of logic between the
//   two registers, and the pad shift registers update in that same cycle.
//   Reset: rst_n low at a clock edge clears both valid flags, all shift
//   registers, the strobe level and the auto-read words.
//   Stall: while out_tready is low the result is held; one more word is
//   still taken into an empty input register, after which in_tready drops.
module joypad_serial_port_multitap_top (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // [0] strobe_value, [16:1] pad0_buttons, [32:17] pad1_buttons,
  // [48:33] pad2_buttons, [64:49] pad3_buttons, [80:65] pad4_buttons,
  // [85:81] connected_mask, [86] port_select, [87] zero
  input  logic [jspm_pkg::IN_DATA_W-1:0]  in_tdata,
  // [1:0] command
  input  logic [1:0]                      in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [4:0] read_data, [20:5] joy_word1, [36:21] joy_word2,
  // [52:37] joy_word3, [68:53] joy_word4, [71:69] zero
  output logic [jspm_pkg::OUT_DATA_W-1:0] out_tdata
);

  logic            take;
  logic            item_valid;
  jspm_pkg::item_t item;

  // Input register
  jspm_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .take       (take),
    .item_valid (item_valid),
    .item       (item)
  );

  // State, command logic and result register
  jspm_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .item       (item),
    .take       (take),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
